@@ src/hwp_pkg.sv @@
// Shared types and constants for the hex waveform record parser.
`default_nettype none
package hwp_pkg;

	typedef struct packed {
		logic       operation;
		logic [7:0] rx_byte;
		logic       link_error;
	} in_word_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] sample_value;
		logic [9:0] sample_index;
		logic [7:0] min_value;
		logic [7:0] max_value;
	} out_word_t;

	// classified byte, front to back
	typedef struct packed {
		logic       start;
		logic       link_error;
		logic [7:0] rx_byte;
		logic       hex_ok;
		logic [3:0] nibble;
		logic       is_comma;
		logic       is_cr;
		logic       is_lf;
	} cls_word_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ECHO,
		PH_HEADER,
		PH_HEX,
		PH_SEP,
		PH_LF
	} phase_t;

	localparam logic       OP_START     = 1'b1;

	localparam logic [1:0] KIND_SAMPLE  = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_FAIL    = 2'd2;

	localparam logic       CFG_CHANNEL  = 1'b0;
	localparam logic       CFG_LENGTH   = 1'b1;

	localparam int         CFG_W        = 11;
	localparam logic [3:0] CHANNEL_RST  = 4'd1;
	localparam logic [10:0] LENGTH_RST  = 11'd1008;

	localparam int         MID_DEPTH    = 4;
	localparam int         OUT_DEPTH    = 2;

	localparam logic [7:0] CH_T         = 8'h54;
	localparam logic [7:0] CH_R         = 8'h52;
	localparam logic [7:0] CH_C         = 8'h43;
	localparam logic [7:0] CH_A         = 8'h41;
	localparam logic [7:0] CH_F         = 8'h46;
	localparam logic [7:0] CH_0         = 8'h30;
	localparam logic [7:0] CH_9         = 8'h39;
	localparam logic [7:0] CH_EQ        = 8'h3D;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_H         = 8'h48;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_LF        = 8'h0A;

endpackage
`default_nettype wire

@@ src/hwp_fifo.sv @@
// Small register queue between pipeline parts.
`default_nettype none
module hwp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ src/hwp_front.sv @@
// Front part: accepts input words and classifies the received byte.
`default_nettype none
module hwp_front (
	input  wire logic             push,
	input  wire hwp_pkg::in_word_t item,
	input  wire logic             mid_full,
	output logic                  mid_wr,
	output hwp_pkg::cls_word_t    cls
);
	import hwp_pkg::*;

	logic is_dec;
	logic is_alpha;

	assign mid_wr   = push && !mid_full;
	assign is_dec   = (item.rx_byte >= CH_0) && (item.rx_byte <= CH_9);
	assign is_alpha = (item.rx_byte >= CH_A) && (item.rx_byte <= CH_F);

	always_comb begin
		cls.start      = (item.operation == OP_START);
		cls.link_error = item.link_error;
		cls.rx_byte    = item.rx_byte;
		cls.hex_ok     = is_dec || is_alpha;
		cls.nibble     = is_alpha ? item.rx_byte[3:0] + 4'd9 : item.rx_byte[3:0];
		cls.is_comma   = (item.rx_byte == CH_COMMA);
		cls.is_cr      = (item.rx_byte == CH_CR);
		cls.is_lf      = (item.rx_byte == CH_LF);
	end
endmodule
`default_nettype wire

@@ src/hwp_back.sv @@
// Back part: record parse state machine, sample decode and min/max tracking.
`default_nettype none
module hwp_back #(
	parameter int MAX_RECORD = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               mid_valid,
	input  wire hwp_pkg::cls_word_t cls,
	output logic                    mid_rd,
	input  wire logic               out_full,
	output logic                    out_wr,
	output hwp_pkg::out_word_t      res,
	input  wire logic [3:0]         channel_digit,
	input  wire logic [10:0]        record_length
);
	import hwp_pkg::*;

	localparam int LEN_CAP = (MAX_RECORD > 2047) ? 2047 : MAX_RECORD;
	localparam int CNT_W   = $clog2(LEN_CAP + 1);

	phase_t           phase_q, phase_d;
	logic [2:0]       pos_q, pos_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [3:0]       hi_q, hi_d;
	logic             pend_q, pend_d;
	logic [7:0]       min_q, min_d;
	logic [7:0]       max_q, max_d;

	logic             take;
	logic [16:0]      len_ext;
	logic [16:0]      eff_len;
	logic             at_end;
	logic [7:0]       echo_ch;
	logic [7:0]       hdr_ch;
	logic [7:0]       sample;
	logic [31:0]      idx_ext;

	assign take    = mid_valid && !out_full;
	assign mid_rd  = take;
	assign len_ext = 17'(record_length);
	assign eff_len = (len_ext == '0) ? 17'd1 :
		(len_ext > 17'(MAX_RECORD)) ? 17'(MAX_RECORD) : len_ext;
	assign at_end  = (17'(count_q) >= eff_len);
	assign sample  = {hi_q, cls.nibble};
	assign idx_ext = 32'(count_q);

	always_comb begin
		unique case (pos_q)
			3'd0:    echo_ch = CH_T;
			3'd1:    echo_ch = CH_R;
			3'd2:    echo_ch = CH_C;
			3'd3:    echo_ch = CH_0 + {4'h0, channel_digit};
			default: echo_ch = CH_A;
		endcase
		unique case (pos_q)
			3'd0:    hdr_ch = CH_EQ;
			3'd1:    hdr_ch = CH_HASH;
			3'd2:    hdr_ch = CH_H;
			default: hdr_ch = ~cls.rx_byte;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		count_d = count_q;
		hi_d    = hi_q;
		pend_d  = pend_q;
		min_d   = min_q;
		max_d   = max_q;
		out_wr  = 1'b0;
		res.kind         = KIND_FAIL;
		res.sample_value = '0;
		res.sample_index = '0;

		if (take) begin
			if (cls.start) begin
				phase_d = PH_ECHO;
				pos_d   = '0;
				count_d = '0;
				hi_d    = '0;
				pend_d  = 1'b0;
				min_d   = 8'hFF;
				max_d   = 8'h00;
			end else if (phase_q != PH_IDLE) begin
				if (cls.link_error) begin
					phase_d = PH_IDLE;
					out_wr  = 1'b1;
				end else begin
					unique case (phase_q)
						PH_ECHO: begin
							if (cls.rx_byte != echo_ch) begin
								phase_d = PH_IDLE;
								out_wr  = 1'b1;
							end else if (pos_q == 3'd4) begin
								phase_d = PH_HEADER;
								pos_d   = '0;
							end else begin
								pos_d = pos_q + 3'd1;
							end
						end
						PH_HEADER: begin
							if (cls.rx_byte != hdr_ch) begin
								phase_d = PH_IDLE;
								out_wr  = 1'b1;
							end else if (pos_q == 3'd2) begin
								phase_d = PH_HEX;
								pos_d   = '0;
								pend_d  = 1'b0;
							end else begin
								pos_d = pos_q + 3'd1;
							end
						end
						PH_HEX: begin
							if (!cls.hex_ok) begin
								phase_d = PH_IDLE;
								out_wr  = 1'b1;
							end else if (!pend_q) begin
								hi_d   = cls.nibble;
								pend_d = 1'b1;
							end else begin
								pend_d  = 1'b0;
								count_d = count_q + 1'b1;
								if (sample < min_q) begin
									min_d = sample;
								end
								if (sample > max_q) begin
									max_d = sample;
								end
								phase_d          = PH_SEP;
								out_wr           = 1'b1;
								res.kind         = KIND_SAMPLE;
								res.sample_value = sample;
								res.sample_index = idx_ext[9:0];
							end
						end
						PH_SEP: begin
							if (at_end ? !cls.is_cr : !cls.is_comma) begin
								phase_d = PH_IDLE;
								out_wr  = 1'b1;
							end else begin
								phase_d = at_end ? PH_LF : PH_HEX;
							end
						end
						PH_LF: begin
							phase_d = PH_IDLE;
							out_wr  = 1'b1;
							if (cls.is_lf) begin
								res.kind = KIND_DONE;
							end
						end
						default: begin
							phase_d = PH_IDLE;
						end
					endcase
				end
			end
		end
		res.min_value = min_d;
		res.max_value = max_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			count_q <= '0;
			hi_q    <= '0;
			pend_q  <= 1'b0;
			min_q   <= 8'hFF;
			max_q   <= 8'h00;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			count_q <= count_d;
			hi_q    <= hi_d;
			pend_q  <= pend_d;
			min_q   <= min_d;
			max_q   <= max_d;
		end
	end
endmodule
`default_nettype wire

@@ src/hex_waveform_record_parser.sv @@
// Top level of the hex waveform record parser.
// Usage:
//   Input queue side: drive item and raise push; the word is taken at a rising
//   edge with push high and full low. operation selects a received byte or the
//   start of a new record (start resets the parse and min/max, no result).
//   Result queue side: while empty is low, result holds the oldest result word;
//   it is taken at a rising edge with pop high. Each byte gives at most one
//   result: a decoded sample, record complete, or record failed.
//   Configuration: cfg_we writes cfg_data to register cfg_index (channel digit,
//   record length) at the clock edge; write only while no words are in flight.
//   Order: an accepted word is classified into the 4-entry middle queue; the
//   parser reads it from there and writes any result into the result queue.
//   Throughput: one byte per cycle while the result queue is not full.
//   If pop stays low, the 2-entry result queue fills, the parser stops, the
//   middle queue fills and full rises; nothing is lost.
//   Reset (arst_n low) empties both queues, sets the parser idle and loads the
//   register defaults (channel 1, length 1008).
`default_nettype none
module hex_waveform_record_parser #(
	parameter int MAX_RECORD = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire hwp_pkg::in_word_t          item,
	output logic                            empty,
	input  wire logic                       pop,
	output hwp_pkg::out_word_t              result,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [hwp_pkg::CFG_W-1:0]  cfg_data
);
	import hwp_pkg::*;

	logic [3:0]  channel_q;
	logic [10:0] length_q;

	logic        mid_wr;
	logic        mid_rd;
	logic        mid_empty;
	cls_word_t   cls_in;
	cls_word_t   cls_out;
	logic        out_wr;
	logic        out_full;
	out_word_t   res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= CHANNEL_RST;
			length_q  <= LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHANNEL: channel_q <= cfg_data[3:0];
				CFG_LENGTH:  length_q  <= cfg_data;
				default:     ;
			endcase
		end
	end

	hwp_front u_front (
		.push     (push),
		.item     (item),
		.mid_full (full),
		.mid_wr   (mid_wr),
		.cls      (cls_in)
	);

	hwp_fifo #(
		.WIDTH ($bits(cls_word_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_data (cls_in),
		.rd_en   (mid_rd),
		.rd_data (cls_out),
		.full    (full),
		.empty   (mid_empty)
	);

	hwp_back #(
		.MAX_RECORD (MAX_RECORD)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.mid_valid     (!mid_empty),
		.cls           (cls_out),
		.mid_rd        (mid_rd),
		.out_full      (out_full),
		.out_wr        (out_wr),
		.res           (res),
		.channel_digit (channel_q),
		.record_length (length_q)
	);

	hwp_fifo #(
		.WIDTH ($bits(out_word_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data (res),
		.rd_en   (pop),
		.rd_data (result),
		.full    (out_full),
		.empty   (empty)
	);
endmodule
`default_nettype wire

@@ src/hwp_checker.sv @@
// Port-level checks for the hex waveform record parser, bound to the top level.
`default_nettype none
module hwp_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      empty,
	input wire logic                      pop,
	input wire hwp_pkg::out_word_t        result
);
	import hwp_pkg::*;

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.kind == KIND_SAMPLE || result.kind == KIND_DONE ||
			result.kind == KIND_FAIL))
		else $error("result kind out of range");

	a_non_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind != KIND_SAMPLE) |->
			(result.sample_value == '0 && result.sample_index == '0))
		else $error("non-sample result carries sample fields");

	a_sample_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == KIND_SAMPLE) |->
			(result.min_value <= result.sample_value &&
			 result.sample_value <= result.max_value))
		else $error("sample outside running min/max");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result word changed");
endmodule

bind hex_waveform_record_parser hwp_checker u_hwp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
`default_nettype wire

@@ sim/hwp_record_checker.sv @@
// Checker for the hex waveform record parser: predicts each result word and compares it.
`default_nettype none
module hwp_record_checker #(
	parameter int MAX_RECORD = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire logic                      full,
	input  wire hwp_pkg::in_word_t         item,
	input  wire logic                      empty,
	input  wire logic                      pop,
	input  wire hwp_pkg::out_word_t        result,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [hwp_pkg::CFG_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             outstanding
);
	import hwp_pkg::*;

	phase_t      phase;
	logic [2:0]  match_pos;
	logic [10:0] samples_seen;
	logic [3:0]  upper_nibble;
	logic        nibble_held;
	logic [7:0]  min_seen;
	logic [7:0]  max_seen;
	logic [3:0]  channel;
	logic [10:0] length;
	out_word_t   expected_words[$];

	function automatic logic [10:0] clamp_length(input logic [10:0] l);
		if (l == 0)
			return 11'd1;
		if (l > MAX_RECORD)
			return 11'(MAX_RECORD);
		return l;
	endfunction

	// bit 4 set when the byte is an upper-case hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		if (b >= CH_0 && b <= CH_9)
			return {1'b1, 4'(b - CH_0)};
		if (b >= CH_A && b <= CH_F)
			return {1'b1, 4'(b - CH_A + 8'd10)};
		return 5'd0;
	endfunction

	function automatic logic [7:0] echo_byte(input logic [2:0] p);
		case (p)
			3'd0: return CH_T;
			3'd1: return CH_R;
			3'd2: return CH_C;
			3'd3: return CH_0 + {4'd0, channel};
			default: return CH_A;
		endcase
	endfunction

	function automatic logic [7:0] header_byte(input logic [2:0] p);
		case (p)
			3'd0: return CH_EQ;
			3'd1: return CH_HASH;
			default: return CH_H;
		endcase
	endfunction

	task automatic expect_word(input logic [1:0] k, input logic [7:0] v, input logic [9:0] idx);
		out_word_t w;
		w.kind = k;
		w.sample_value = v;
		w.sample_index = idx;
		w.min_value = min_seen;
		w.max_value = max_seen;
		expected_words.push_back(w);
	endtask

	task automatic fail_record();
		phase = PH_IDLE;
		expect_word(KIND_FAIL, 8'd0, 10'd0);
	endtask

	task automatic parse_byte(input in_word_t w);
		logic [4:0] d;
		logic [7:0] v;
		d = hex_digit(w.rx_byte);
		if (w.operation == OP_START) begin
			phase = PH_ECHO;
			match_pos = 0;
			samples_seen = 0;
			upper_nibble = 0;
			nibble_held = 0;
			min_seen = 8'hFF;
			max_seen = 8'h00;
		end else if (phase != PH_IDLE) begin
			if (w.link_error)
				fail_record();
			else case (phase)
				PH_ECHO: begin
					if (w.rx_byte != echo_byte(match_pos)) begin
						fail_record();
					end else begin
						match_pos++;
						if (match_pos == 3'd5) begin
							phase = PH_HEADER;
							match_pos = 0;
						end
					end
				end
				PH_HEADER: begin
					if (w.rx_byte != header_byte(match_pos)) begin
						fail_record();
					end else begin
						match_pos++;
						if (match_pos == 3'd3) begin
							phase = PH_HEX;
							match_pos = 0;
							nibble_held = 0;
						end
					end
				end
				PH_HEX: begin
					if (!d[4]) begin
						fail_record();
					end else if (!nibble_held) begin
						upper_nibble = d[3:0];
						nibble_held = 1;
					end else begin
						nibble_held = 0;
						v = {upper_nibble, d[3:0]};
						if (v < min_seen)
							min_seen = v;
						if (v > max_seen)
							max_seen = v;
						expect_word(KIND_SAMPLE, v, samples_seen[9:0]);
						samples_seen++;
						phase = PH_SEP;
					end
				end
				PH_SEP: begin
					if (samples_seen >= clamp_length(length)) begin
						if (w.rx_byte != CH_CR)
							fail_record();
						else
							phase = PH_LF;
					end else if (w.rx_byte != CH_COMMA) begin
						fail_record();
					end else begin
						phase = PH_HEX;
					end
				end
				PH_LF: begin
					if (w.rx_byte != CH_LF) begin
						fail_record();
					end else begin
						phase = PH_IDLE;
						expect_word(KIND_DONE, 8'd0, 10'd0);
					end
				end
				default: phase = PH_IDLE;
			endcase
		end
	endtask

	task automatic report(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_word(input out_word_t got);
		out_word_t want;
		if (expected_words.size() == 0) begin
			report("unexpected word, kind", got.kind, -1);
		end else begin
			want = expected_words.pop_front();
			if (got.kind != want.kind)
				report("kind", got.kind, want.kind);
			if (got.sample_value != want.sample_value)
				report("sample_value", got.sample_value, want.sample_value);
			if (got.sample_index != want.sample_index)
				report("sample_index", got.sample_index, want.sample_index);
			if (got.min_value != want.min_value)
				report("min_value", got.min_value, want.min_value);
			if (got.max_value != want.max_value)
				report("max_value", got.max_value, want.max_value);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_IDLE;
			match_pos = 0;
			samples_seen = 0;
			upper_nibble = 0;
			nibble_held = 0;
			min_seen = 8'hFF;
			max_seen = 8'h00;
			channel = CHANNEL_RST;
			length = LENGTH_RST;
			expected_words.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (!empty && pop)
				check_word(result);
			if (cfg_we) begin
				if (cfg_index == CFG_CHANNEL)
					channel = cfg_data[3:0];
				else
					length = cfg_data;
			end
			if (push && !full)
				parse_byte(item);
			outstanding = expected_words.size();
		end
	end

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Testbench top for the hex waveform record parser: stimulus, handshakes and verdict.
`default_nettype none
module testbench;
	import hwp_pkg::*;

	localparam int   MAX_RECORD   = 1024;
	localparam int   ITEMS        = 1950;
	localparam int   SETTLE       = 10;
	localparam int   CYCLE_LIMIT  = 400000;
	localparam logic OP_BYTE      = ~OP_START;

	logic             clk;
	logic             arst_n;
	logic             push;
	logic             full;
	in_word_t         item;
	logic             empty;
	logic             pop;
	out_word_t        result;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int               mismatches;
	int               outstanding;
	int               cycles;
	int               words_sent;
	bit               calm;
	logic [3:0]       channel_set;
	logic [10:0]      length_set;

	hex_waveform_record_parser #(.MAX_RECORD(MAX_RECORD)) i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	hwp_record_checker #(.MAX_RECORD(MAX_RECORD)) i_check (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("hex_waveform_record_parser verification failed");
			$finish;
		end
	end

	initial begin
		pop = 1'b0;
		forever begin
			@(posedge clk);
			pop <= calm || $urandom_range(99) >= 35;
		end
	end

	function automatic in_word_t mk(input logic op, input logic [7:0] b, input logic e);
		in_word_t w;
		w.operation = op;
		w.rx_byte = b;
		w.link_error = e;
		return w;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		return d < 4'd10 ? CH_0 + {4'd0, d} : CH_A + {4'd0, d} - 8'd10;
	endfunction

	function automatic int samples_per_record(input logic [10:0] l);
		if (l == 0)
			return 1;
		return l > MAX_RECORD ? MAX_RECORD : int'(l);
	endfunction

	task automatic send_word(input in_word_t w);
		bit taken;
		while (!calm && $urandom_range(99) < 35) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic e);
		send_word(mk(OP_BYTE, b, e));
	endtask

	// lets the parser drain: all results back, then words with no result
	task automatic settle();
		push <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CHANNEL)
			channel_set = data[3:0];
		else
			length_set = data;
	endtask

	task automatic set_config(input logic [3:0] ch, input logic [10:0] len);
		write_reg(CFG_CHANNEL, {7'($urandom), ch});
		write_reg(CFG_LENGTH, len);
	endtask

	// one reply; clean forces a well-formed record, cut truncates it
	task automatic send_record(input bit clean, input int cut);
		in_word_t   rec[$];
		int         n;
		int         mode;
		int         at;
		logic [7:0] v;
		n = samples_per_record(length_set);
		mode = clean ? 0 : $urandom_range(9);
		if (mode == 8)
			n = (n > 1 && $urandom_range(1)) ? n - 1 : n + 1;
		rec.push_back(mk(OP_START, 8'($urandom), 1'($urandom_range(1))));
		rec.push_back(mk(OP_BYTE, CH_T, 1'b0));
		rec.push_back(mk(OP_BYTE, CH_R, 1'b0));
		rec.push_back(mk(OP_BYTE, CH_C, 1'b0));
		rec.push_back(mk(OP_BYTE, CH_0 + {4'd0, channel_set}, 1'b0));
		rec.push_back(mk(OP_BYTE, CH_A, 1'b0));
		rec.push_back(mk(OP_BYTE, CH_EQ, 1'b0));
		rec.push_back(mk(OP_BYTE, CH_HASH, 1'b0));
		rec.push_back(mk(OP_BYTE, CH_H, 1'b0));
		for (int i = 0; i < n; i++) begin
			v = 8'($urandom);
			rec.push_back(mk(OP_BYTE, hex_char(v[7:4]), 1'b0));
			rec.push_back(mk(OP_BYTE, hex_char(v[3:0]), 1'b0));
			if (i == n - 1) begin
				rec.push_back(mk(OP_BYTE, CH_CR, 1'b0));
				rec.push_back(mk(OP_BYTE, CH_LF, 1'b0));
			end else begin
				rec.push_back(mk(OP_BYTE, CH_COMMA, 1'b0));
			end
		end
		at = $urandom_range(1, rec.size() - 1);
		case (mode)
			5: if (cut == 0 || at < cut) cut = at;
			6: rec[at].rx_byte = 8'($urandom);
			7: rec[at].link_error = 1'b1;
			9: case ($urandom_range(4))
				0: rec[at].rx_byte = 8'h61 + 8'($urandom_range(5));
				1: rec[at].rx_byte = CH_9 + 8'd1;
				2: rec[at].rx_byte = CH_0 - 8'd1;
				3: rec[at].rx_byte = CH_A - 8'd1;
				default: rec[at].rx_byte = CH_F + 8'd1;
			endcase
			default: ;
		endcase
		if (cut > 0)
			while (rec.size() > cut)
				void'(rec.pop_back());
		foreach (rec[i])
			send_word(rec[i]);
		words_sent += rec.size();
		repeat ($urandom_range(2))
			send_byte(8'($urandom), 1'($urandom_range(1)));
	endtask

	initial begin
		int phase_no;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_CHANNEL;
		cfg_data = '0;
		cycles = 0;
		words_sent = 0;
		calm = 1'b0;
		channel_set = CHANNEL_RST;
		length_set = LENGTH_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes before any start are dropped
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		set_config(4'd0, 11'd2);
		// extreme samples, start with its other fields set
		send_word(mk(OP_START, 8'hFF, 1'b1));
		send_byte(CH_T, 1'b0);
		send_byte(CH_R, 1'b0);
		send_byte(CH_C, 1'b0);
		send_byte(CH_0, 1'b0);
		send_byte(CH_A, 1'b0);
		send_byte(CH_EQ, 1'b0);
		send_byte(CH_HASH, 1'b0);
		send_byte(CH_H, 1'b0);
		send_byte(CH_0, 1'b0);
		send_byte(CH_0, 1'b0);
		send_byte(CH_COMMA, 1'b0);
		send_byte(CH_F, 1'b0);
		send_byte(CH_F, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b0);
		// link error on a correct byte, then a byte after the failure
		send_word(mk(OP_START, 8'h00, 1'b0));
		send_byte(CH_T, 1'b0);
		send_byte(CH_R, 1'b1);
		send_byte(CH_C, 1'b0);
		words_sent += 21;

		set_config(4'd15, 11'd1);
		repeat (4) send_record(1'b0, 0);
		set_config(4'd9, 11'd0);
		repeat (4) send_record(1'b0, 0);
		// length above the maximum, record cut short
		set_config(4'd10, 11'd2047);
		send_record(1'b1, 60);
		set_config(4'd3, 11'd1024);
		repeat (2) send_record(1'b0, 40);

		phase_no = 0;
		while (words_sent < ITEMS) begin
			calm = phase_no == 3 || phase_no == 4;
			case ($urandom_range(19))
				0: set_config(4'($urandom), 11'd0);
				1: set_config(4'($urandom), 11'd1);
				default: set_config(4'($urandom), 11'($urandom_range(2, 9)));
			endcase
			repeat ($urandom_range(3, 8)) send_record(1'b0, 0);
			phase_no++;
		end
		calm = 1'b0;

		settle();
		if (mismatches == 0)
			$display("hex_waveform_record_parser verification clean");
		else
			$display("hex_waveform_record_parser verification failed");
		$finish;
	end

endmodule
`default_nettype wire

@@ hex_waveform_record_parser.f @@
src/hwp_pkg.sv
src/hwp_fifo.sv
src/hwp_front.sv
src/hwp_back.sv
src/hex_waveform_record_parser.sv
src/hwp_checker.sv
sim/hwp_record_checker.sv
sim/testbench.sv
